[rtl/deq_pkg.sv]
// ============================================================================
// deq_pkg - shared types and constants of the double-ended queue
// Command codes, default store depth and the word structs of both channels.
// ============================================================================
package deq_pkg;

    // Default number of entries in the word store.
    localparam int DEQ_DEPTH = 256;

    // Width of one stored word.
    localparam int DEQ_WORD_W = 32;

    // Width of the entry count field in a result word.
    localparam int DEQ_CNT_W = 9;

    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_BACK   = 2'd3
    } t_cmd;

    // One command word.
    typedef struct packed {
        t_cmd                  cmd;
        logic [DEQ_WORD_W-1:0] push_word;
    } t_deq_in;

    // One result word.
    typedef struct packed {
        logic [DEQ_WORD_W-1:0] popped_word;
        logic [DEQ_CNT_W-1:0]  entry_count;
        logic                  error_flag;
    } t_deq_out;

endpackage

[rtl/deq_ram.sv]
// ============================================================================
// deq_ram - generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/double_ended_queue.sv]
// ============================================================================
// double_ended_queue - double-ended queue of 32-bit words
// Circular word store in a synchronous RAM, addressed by a front pointer and
// a count. Push or pop at either end, one result word per command.
// ============================================================================
//
//  Channel   Handshake          Payload   Direction
//  -------   ----------------   -------   ---------
//  command   start / busy       i_in      in
//  result    o_done (strobe)    o_out     out
//
// A command is taken at every rising edge where start is high and busy is low.
// Its result appears in the next cycle, for exactly one cycle, with o_done high.
// The pointers are updated at the accepting edge and, unless the command
// fails, the RAM is written or read there; a command may be given in every
// cycle and busy stays low. The result waits on the store's read register.
// Reset (i_rst_n low, synchronous) empties the queue; the store itself is not
// cleared, since only entries written by a push are ever read back.
// The receiver cannot stall: a result not taken in its cycle is gone.
//
module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH = DEQ_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_deq_in  i_in,
    output logic     o_done,
    output t_deq_out o_out
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam logic [SW-1:0] DEPTH_SUM = SW'(DEPTH);

    // Front pointer and number of held words.
    logic [AW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;

    // Result control: strobe, error and whether RAM data is the popped word.
    logic r_done, n_done;
    logic r_err, n_err;
    logic r_pop_ok, n_pop_ok;

    logic accept;
    logic full;
    logic empty;

    logic [AW-1:0] front_dec;
    logic [AW-1:0] front_inc;
    logic [SW-1:0] tail_sum;
    logic [SW-1:0] last_sum;
    logic [AW-1:0] tail_slot;
    logic [AW-1:0] last_slot;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [DEQ_WORD_W-1:0] ram_rdata;

    // Every command finishes in the cycle it is taken, so no hold-off.
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    assign full  = (r_count == FULL_CNT);
    assign empty = (r_count == '0);

    // Pointer arithmetic wraps modulo DEPTH. Sums stay below twice DEPTH, so
    // a single compare and subtract brings them back into range.
    assign front_dec = (r_front == '0) ? LAST_IDX : r_front - AW'(1);
    assign front_inc = (r_front == LAST_IDX) ? '0 : r_front + AW'(1);

    assign tail_sum  = SW'(r_front) + SW'(r_count);
    assign last_sum  = tail_sum - SW'(1);
    assign tail_slot = AW'((tail_sum >= DEPTH_SUM) ? tail_sum - DEPTH_SUM : tail_sum);
    assign last_slot = AW'((last_sum >= DEPTH_SUM) ? last_sum - DEPTH_SUM : last_sum);

    always_comb begin
        n_front   = r_front;
        n_count   = r_count;
        n_done    = accept;
        n_err     = 1'b0;
        n_pop_ok  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = tail_slot;
        ram_re    = 1'b0;
        ram_raddr = r_front;
        if (accept) begin
            unique case (i_in.cmd)
                CMD_PUSH_FRONT: begin
                    if (full) begin
                        n_err = 1'b1;
                    end else begin
                        n_front   = front_dec;
                        n_count   = r_count + CW'(1);
                        ram_we    = 1'b1;
                        ram_waddr = front_dec;
                    end
                end
                CMD_PUSH_BACK: begin
                    if (full) begin
                        n_err = 1'b1;
                    end else begin
                        n_count   = r_count + CW'(1);
                        ram_we    = 1'b1;
                        ram_waddr = tail_slot;
                    end
                end
                CMD_POP_FRONT: begin
                    if (empty) begin
                        n_err = 1'b1;
                    end else begin
                        n_front   = front_inc;
                        n_count   = r_count - CW'(1);
                        n_pop_ok  = 1'b1;
                        ram_re    = 1'b1;
                        ram_raddr = r_front;
                    end
                end
                CMD_POP_BACK: begin
                    if (empty) begin
                        n_err = 1'b1;
                    end else begin
                        n_count   = r_count - CW'(1);
                        n_pop_ok  = 1'b1;
                        ram_re    = 1'b1;
                        ram_raddr = last_slot;
                    end
                end
                default: begin
                    n_err = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front  <= '0;
            r_count  <= '0;
            r_done   <= 1'b0;
            r_err    <= 1'b0;
            r_pop_ok <= 1'b0;
        end else begin
            r_front  <= n_front;
            r_count  <= n_count;
            r_done   <= n_done;
            r_err    <= n_err;
            r_pop_ok <= n_pop_ok;
        end
    end

    deq_ram #(
        .WIDTH (DEQ_WORD_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_in.push_word),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // During the result cycle r_count still holds the count after the command,
    // because a new command only changes it at the edge that ends this cycle.
    // The count is sized to the result field; the field holds any DEPTH up to
    // 511 without loss.
    assign o_done            = r_done;
    assign o_out.popped_word = r_pop_ok ? ram_rdata : '0;
    assign o_out.entry_count = DEQ_CNT_W'(r_count);
    assign o_out.error_flag  = r_err;

endmodule

[dv/tb_double_ended_queue.sv]
// ============================================================================
// tb_double_ended_queue - self-checking testbench of the double-ended queue
// Drives push and pop commands at both ends and predicts each result word
// with a circular-buffer model. Every returned word is compared field by
// field. The run covers empty pops, full pushes, pointer wrap and idle gaps.
// ============================================================================
module tb_double_ended_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    // ------------------------------------------------------------------------
    // Scoreboard: a shadow copy of the queue state predicts every result word
    // at the moment its command is accepted, and holds the predictions in
    // order until the block returns the matching words.
    // ------------------------------------------------------------------------
    class deque_scoreboard;
        logic [DEQ_WORD_W-1:0] word_store [DEQ_DEPTH];
        int unsigned           front_idx;
        int unsigned           held;
        t_deq_out              result_q [$];
        int                    failures;

        function new();
            foreach (word_store[i]) word_store[i] = '0;
            front_idx = 0;
            held      = 0;
            failures  = 0;
        endfunction

        function int pending();
            return result_q.size();
        endfunction

        // Applies one accepted command to the shadow queue and queues the
        // result word that the block must return for it.
        function void note_command(t_deq_in w);
            t_deq_out r;
            r = '0;
            case (w.cmd)
                CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                    if (held >= DEQ_DEPTH) begin
                        // A push on a full queue drops the word.
                        r.error_flag = 1'b1;
                    end else if (w.cmd == CMD_PUSH_FRONT) begin
                        front_idx = (front_idx + DEQ_DEPTH - 1) % DEQ_DEPTH;
                        word_store[front_idx] = w.push_word;
                        held++;
                    end else begin
                        word_store[(front_idx + held) % DEQ_DEPTH] = w.push_word;
                        held++;
                    end
                end
                default: begin
                    if (held == 0) begin
                        // A pop on an empty queue returns zero.
                        r.error_flag = 1'b1;
                    end else if (w.cmd == CMD_POP_FRONT) begin
                        r.popped_word = word_store[front_idx];
                        front_idx = (front_idx + 1) % DEQ_DEPTH;
                        held--;
                    end else begin
                        r.popped_word = word_store[(front_idx + held - 1) % DEQ_DEPTH];
                        held--;
                    end
                end
            endcase
            r.entry_count = DEQ_CNT_W'(held);
            result_q.push_back(r);
        endfunction

        // Compares one returned word with the oldest prediction.
        function void check_result(t_deq_out got);
            t_deq_out want;
            if (result_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: result word %h with no command outstanding", $time, got);
                return;
            end
            want = result_q.pop_front();
            if (got.popped_word !== want.popped_word ||
                got.entry_count !== want.entry_count ||
                got.error_flag !== want.error_flag) begin
                failures++;
                if (failures <= 10)
                    $display({"%0t: MISMATCH popped_word exp %h got %h, ",
                              "entry_count exp %0d got %0d, error_flag exp %b got %b"},
                             $time, want.popped_word, got.popped_word,
                             want.entry_count, got.entry_count,
                             want.error_flag, got.error_flag);
            end
        endfunction
    endclass

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_deq_in  i_in;
    logic     o_done;
    t_deq_out o_out;

    deque_scoreboard sb = new();

    double_ended_queue DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_in    (i_in),
        .o_done  (o_done),
        .o_out   (o_out)
    );

    // 20 ns clock period.
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Monitor. All handshake signals are read at the rising edge, before any
    // update scheduled at that edge takes effect. The command is noted first
    // so that a result returned in the same cycle still finds its prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            sb.note_command(i_in);
        if (i_rst_n && o_done)
            sb.check_result(o_out);
    end

    // Draws a run of idle cycles: each further cycle is idle with the given
    // chance in percent, so a zero chance gives back-to-back commands.
    function int draw_gap(int idle_pct);
        int g;
        g = 0;
        while ($urandom_range(99) < idle_pct)
            g++;
        return g;
    endfunction

    // Draws a random command word. The push chance steers the queue toward
    // full or toward empty; the data field is random on pops as well.
    function t_deq_in draw_command(int push_pct);
        t_deq_in w;
        if ($urandom_range(99) < push_pct)
            w.cmd = ($urandom_range(1) != 0) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        else
            w.cmd = ($urandom_range(1) != 0) ? CMD_POP_BACK : CMD_POP_FRONT;
        w.push_word = $urandom;
        return w;
    endfunction

    // Presents one command word after the given number of idle cycles and
    // returns at the edge that accepts it. Start is only lowered when a gap
    // follows, so it never toggles twice within one time step.
    task automatic issue_command(input t_cmd cmd, input logic [DEQ_WORD_W-1:0] data,
                                 input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_in.cmd       <= cmd;
        i_in.push_word <= data;
        do @(posedge i_clk); while (busy);
    endtask

    // Holds the sender off until every outstanding result word has come back.
    // The first edge lets the monitor note the command accepted last.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // One random stretch of commands with a fixed push bias and idle rate.
    task automatic run_phase(input int count, input int push_pct, input int idle_pct);
        t_deq_in w;
        repeat (count) begin
            w = draw_command(push_pct);
            issue_command(w.cmd, w.push_word, draw_gap(idle_pct));
        end
    endtask

    initial begin
        int guard;

        i_rst_n = 1'b0;
        start   = 1'b0;
        i_in    = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Empty pops at both ends, extreme data words, and a
        // push at the front of an empty queue, which wraps the front pointer
        // below zero. The words pushed are then read back from both ends.
        issue_command(CMD_POP_FRONT,  32'hFFFF_FFFF, 0);
        issue_command(CMD_POP_BACK,   32'h0000_0000, 0);
        issue_command(CMD_PUSH_FRONT, 32'hFFFF_FFFF, 0);
        issue_command(CMD_PUSH_BACK,  32'h0000_0000, 0);
        issue_command(CMD_POP_BACK,   32'h5555_5555, 0);
        issue_command(CMD_POP_FRONT,  32'hAAAA_AAAA, 0);
        issue_command(CMD_POP_FRONT,  32'h0000_0000, 0);
        issue_command(CMD_PUSH_BACK,  32'hAAAA_AAAA, 0);
        issue_command(CMD_PUSH_FRONT, 32'h5555_5555, 0);
        issue_command(CMD_PUSH_FRONT, 32'h8000_0001, 0);
        issue_command(CMD_PUSH_BACK,  32'h7FFF_FFFE, 0);
        issue_command(CMD_POP_BACK,   32'h0000_0000, 0);
        issue_command(CMD_POP_FRONT,  32'hFFFF_FFFF, 0);
        issue_command(CMD_POP_BACK,   32'h0000_0000, 0);
        issue_command(CMD_PUSH_BACK,  32'h1234_5678, 0);
        issue_command(CMD_PUSH_BACK,  32'hFEDC_BA98, 0);
        issue_command(CMD_POP_FRONT,  32'h0000_0000, 0);
        issue_command(CMD_POP_FRONT,  32'h0000_0000, 0);
        issue_command(CMD_POP_FRONT,  32'h0000_0000, 0);
        issue_command(CMD_POP_BACK,   32'h0000_0000, 0);

        // Sender pauses until the queue of predictions is empty.
        wait_drained();

        // Fill: mostly pushes back to back. The queue reaches its full depth
        // and then sees several pushes that must be dropped with an error.
        run_phase(300, 98, 0);
        wait_drained();

        // Drain: mostly pops with the sender idle most of the time, ending
        // with pops on an empty queue.
        run_phase(300, 2, 87);

        // Balanced traffic around a small count, with moderate idling and
        // then none, so the pointers keep wrapping in both directions.
        run_phase(150, 50, 33);
        wait_drained();
        run_phase(150, 50, 0);

        start <= 1'b0;

        // Wait for the last result words, with a bound, and keep watching afterwards
        // so that any stray word still shows up as a failure.
        guard = 0;
        @(posedge i_clk);
        while (sb.pending() != 0 && guard < 1000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);

        if (sb.pending() != 0) begin
            sb.failures++;
            $display("%0t: %0d result words never returned", $time, sb.pending());
        end

        if (sb.failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog: stops a run that hangs and reports it as failed.
    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
